// File: design/addressable_led_pulse_encoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the addressable LED pulse encoder
// ----------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_PULSE_ENCODER_DEFINES_SVH
`define ADDRESSABLE_LED_PULSE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define ALPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("alpe: same-cycle check failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define ALPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("alpe: next-cycle check failed");

`endif

// File: design/alpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpe_pkg
// Types and constants shared by the addressable LED pulse encoder.
// ----------------------------------------------------------------------------
package alpe_pkg;

  // Bits sent per pixel: green, red, then blue, MSB first.
  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned BitCntW      = 5;
  localparam logic [BitCntW-1:0] LastBitIdx = BitCntW'(BitsPerPixel - 1);

  localparam int unsigned PixelW  = 24;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AddrW   = RegIdxW + 2;
  localparam int unsigned DataW   = 32;

  // Register indexes
  localparam logic [RegIdxW-1:0] RegZeroHigh = 3'd0;
  localparam logic [RegIdxW-1:0] RegZeroLow  = 3'd1;
  localparam logic [RegIdxW-1:0] RegOneHigh  = 3'd2;
  localparam logic [RegIdxW-1:0] RegOneLow   = 3'd3;
  localparam logic [RegIdxW-1:0] RegLatchGap = 3'd4;

  // Reset values
  localparam logic [7:0]        ZeroHighRst = 8'd8;
  localparam logic [7:0]        ZeroLowRst  = 8'd17;
  localparam logic [7:0]        OneHighRst  = 8'd16;
  localparam logic [7:0]        OneLowRst   = 8'd9;
  localparam logic [TicksW-1:0] LatchGapRst = 16'd1000;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic line_level;
    logic pixel_taken;
    logic holding_full;
    logic sending;
    logic frame_done;
  } out_beat_t;

endpackage

// File: design/addressable_led_pulse_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_pulse_encoder
// Single-wire LED chain waveform generator: one input beat is one line tick.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  in       | in_valid_i / in_ready_o    | in_data_i  (alpe_pkg::in_beat_t)
//  out      | out_valid_o / out_ready_i  | out_data_o (alpe_pkg::out_beat_t)
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One beat per cycle while in_ready_o is high: the tick is evaluated in
// the accept cycle and its result is registered into out_q or skid_q.
// A two-entry output buffer (output register plus skid) keeps in_ready_o
// high while one result waits; input stalls only when both are full.
// Asynchronous active-low reset: line idle, holding empty, timings default.
// ----------------------------------------------------------------------------
module addressable_led_pulse_encoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  alpe_pkg::in_beat_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output alpe_pkg::out_beat_t        out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [alpe_pkg::AddrW-1:0] paddr,
  input  logic [alpe_pkg::DataW-1:0] pwdata,
  output logic [alpe_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import alpe_pkg::*;

`include "addressable_led_pulse_encoder_defines.svh"

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_e;

  // Timing registers
  logic [7:0]        zero_high_q, zero_low_q, one_high_q, one_low_q;
  logic [TicksW-1:0] latch_gap_q;

  // Encoder state
  phase_e              phase_q, phase_d;
  logic [PixelW-1:0]   shift_q, shift_d;
  logic [BitCntW-1:0]  bits_left_q, bits_left_d;
  logic [TicksW-1:0]   ticks_q, ticks_d;
  logic                cur_last_q, cur_last_d;
  logic [PixelW-1:0]   held_pix_q, held_pix_d;
  logic                held_valid_q, held_valid_d;
  logic                held_last_q, held_last_d;

  // Output buffer
  out_beat_t out_q, skid_q, res_d;
  logic      out_valid_q, skid_valid_q;

  logic in_fire, cfg_wr;
  logic [RegIdxW-1:0] reg_idx;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign reg_idx     = paddr[AddrW-1:2];
  assign cfg_wr      = psel && penable && pwrite && pready;

  // --------------------------------------------------------------------------
  // Config port
  always_comb begin
    unique case (reg_idx)
      RegZeroHigh: prdata = DataW'(zero_high_q);
      RegZeroLow:  prdata = DataW'(zero_low_q);
      RegOneHigh:  prdata = DataW'(one_high_q);
      RegOneLow:   prdata = DataW'(one_low_q);
      RegLatchGap: prdata = DataW'(latch_gap_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q <= ZeroHighRst;
      zero_low_q  <= ZeroLowRst;
      one_high_q  <= OneHighRst;
      one_low_q   <= OneLowRst;
      latch_gap_q <= LatchGapRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegZeroHigh: zero_high_q <= pwdata[7:0];
        RegZeroLow:  zero_low_q  <= pwdata[7:0];
        RegOneHigh:  one_high_q  <= pwdata[7:0];
        RegOneLow:   one_low_q   <= pwdata[7:0];
        RegLatchGap: latch_gap_q <= pwdata[TicksW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // One tick
  logic              load0, hv0, last0;
  phase_e            ph0;
  logic [PixelW-1:0] sw0;
  logic [BitCntW-1:0] bl0;
  logic [TicksW-1:0] ticks0, held_high_ticks;

  assign held_high_ticks = held_pix_q[PixelW-1] ? TicksW'(one_high_q) : TicksW'(zero_high_q);

  always_comb begin
    // Start a held pixel when the line is idle
    load0  = (phase_q == PH_IDLE) && held_valid_q;
    ph0    = load0 ? PH_HIGH : phase_q;
    sw0    = load0 ? held_pix_q : shift_q;
    bl0    = load0 ? LastBitIdx : bits_left_q;
    last0  = load0 ? held_last_q : cur_last_q;
    hv0    = load0 ? 1'b0 : held_valid_q;
    ticks0 = load0 ? held_high_ticks : ticks_q;

    phase_d      = ph0;
    shift_d      = sw0;
    bits_left_d  = bl0;
    ticks_d      = ticks0;
    cur_last_d   = last0;
    held_valid_d = hv0;
    held_pix_d   = held_pix_q;
    held_last_d  = held_last_q;

    res_d            = '0;
    res_d.line_level = (ph0 == PH_HIGH);
    res_d.sending    = (ph0 != PH_IDLE);

    if (ph0 != PH_IDLE) begin
      if (ticks0 > TicksW'(1)) begin
        ticks_d = ticks0 - TicksW'(1);
      end else begin
        unique case (ph0)
          PH_HIGH: begin
            phase_d = PH_LOW;
            ticks_d = sw0[PixelW-1] ? TicksW'(one_low_q) : TicksW'(zero_low_q);
          end
          PH_LOW: begin
            priority if (bl0 != '0) begin
              shift_d     = {sw0[PixelW-2:0], 1'b0};
              bits_left_d = bl0 - BitCntW'(1);
              phase_d     = PH_HIGH;
              ticks_d     = sw0[PixelW-2] ? TicksW'(one_high_q) : TicksW'(zero_high_q);
            end else if (last0) begin
              phase_d = PH_LATCH;
              ticks_d = latch_gap_q;
            end else if (hv0) begin
              // Next pixel follows with no gap
              shift_d      = held_pix_q;
              bits_left_d  = LastBitIdx;
              cur_last_d   = held_last_q;
              held_valid_d = 1'b0;
              phase_d      = PH_HIGH;
              ticks_d      = held_high_ticks;
            end else begin
              phase_d = PH_IDLE;
              ticks_d = '0;
            end
          end
          default: begin
            phase_d          = PH_IDLE;
            ticks_d          = '0;
            res_d.frame_done = 1'b1;
          end
        endcase
      end
    end

    // Take the offered pixel if holding is free after the advance
    if (in_data_i.kind && !held_valid_d) begin
      held_pix_d        = {in_data_i.green, in_data_i.red, in_data_i.blue};
      held_last_d       = in_data_i.frame_end;
      held_valid_d      = 1'b1;
      res_d.pixel_taken = 1'b1;
    end
    res_d.holding_full = held_valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      shift_q      <= '0;
      bits_left_q  <= '0;
      ticks_q      <= '0;
      cur_last_q   <= 1'b0;
      held_valid_q <= 1'b0;
      held_last_q  <= 1'b0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      shift_q      <= shift_d;
      bits_left_q  <= bits_left_d;
      ticks_q      <= ticks_d;
      cur_last_q   <= cur_last_d;
      held_valid_q <= held_valid_d;
      held_last_q  <= held_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      held_pix_q <= held_pix_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (out_valid_q && out_ready_i) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (!out_valid_q) begin
        out_valid_q <= in_fire;
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        // hold both entries
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (out_valid_q && out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (!out_valid_q) begin
      out_q <= res_d;
    end else if (in_fire) begin
      skid_q <= res_d;
    end else begin
      // hold both entries
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  `ALPE_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
  `ALPE_ASSERT_NEXT(a_idle_load_starts, in_fire && phase_q == PH_IDLE && held_valid_q,
                    phase_q != PH_IDLE)
  `ALPE_ASSERT_NOW(a_done_from_latch, in_fire && res_d.frame_done, phase_q == PH_LATCH)
  `ALPE_ASSERT_NOW(a_taken_means_full, in_fire && res_d.pixel_taken, res_d.holding_full)

endmodule
